/* rtl/ppc_pkg.sv */
// Shared types, codes and pixel helper functions for the pixel compositor.
package ppc_pkg;

  // Pixel formats as held in the source and destination format registers.
  typedef enum logic [1:0] {
    FMT_A1   = 2'd0,
    FMT_A8   = 2'd1,
    FMT_XRGB = 2'd2,
    FMT_ARGB = 2'd3
  } ppc_fmt_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SRC  = 2'd1,
    ST_DST  = 2'd2,
    ST_FILL = 2'd3
  } ppc_status_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_BLEND_OP   = 3'd0,
    CFG_SRC_FORMAT = 3'd1,
    CFG_DST_FORMAT = 3'd2,
    CFG_USE_FILL   = 3'd3,
    CFG_FILL_COLOR = 3'd4,
    CFG_CHECK_ONLY = 3'd5
  } ppc_cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Premultiplied pixel, one byte per channel.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } ppc_pix_t;

  // Stage enables handed to each blend lane.
  typedef struct packed {
    logic en_mul;
    logic en_div;
  } ppc_lane_ctrl_t;

  // Decodes a raw word of the given format into premultiplied channels.
  function automatic ppc_pix_t ppc_decode(ppc_fmt_e fmt, logic [31:0] w);
    ppc_pix_t p;
    p = '0;
    unique case (fmt)
      FMT_A1:   p.a = (w[7:0] != 8'd0) ? 8'hFF : 8'h00;
      FMT_A8:   p.a = w[7:0];
      FMT_XRGB: p = {8'hFF, w[23:0]};
      FMT_ARGB: p = w;
      default:  p = w;
    endcase
    return p;
  endfunction

  // True when no color channel exceeds alpha.
  function automatic logic ppc_is_premult(ppc_pix_t p);
    return (p.r <= p.a) && (p.g <= p.a) && (p.b <= p.a);
  endfunction

  // Packs a pixel into the destination format.
  function automatic logic [31:0] ppc_encode(ppc_fmt_e fmt, ppc_pix_t p);
    logic [31:0] w;
    unique case (fmt)
      FMT_A1:   w = {31'd0, p.a[7]};
      FMT_A8:   w = {24'd0, p.a};
      FMT_XRGB: w = {8'hFF, p.r, p.g, p.b};
      FMT_ARGB: w = p;
      default:  w = p;
    endcase
    return w;
  endfunction

endpackage

/* rtl/ppc_over_lane.sv */
// One lane: multiply stage, then divide-by-255, add, saturate (Over) or pass s (Src).
module ppc_over_lane
  import ppc_pkg::*;
(
  input  logic           clk_i,
  input  ppc_lane_ctrl_t ctrl_i,
  input  logic           over_i,
  input  logic [7:0]     s_i,
  input  logic [7:0]     d_i,
  input  logic [7:0]     sa_i,
  output logic [7:0]     res_o
);

  logic [15:0] prod_d, prod_q;
  logic [7:0]  s2_q;
  logic        over2_q;
  logic [16:0] quot;
  logic [7:0]  q;
  logic [8:0]  sum;
  logic [7:0]  res_d, res_q;

  // d * (255 - sa) + 127 never exceeds 65152, so 16 bits hold it.
  assign prod_d = 16'(16'(d_i) * 16'(8'd255 - sa_i)) + 16'd127;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      prod_q  <= prod_d;
      s2_q    <= s_i;
      over2_q <= over_i;
    end
  end

  // Exact x / 255 for x below 65535: (x + (x >> 8) + 1) >> 8.
  assign quot = 17'(prod_q) + 17'(prod_q[15:8]) + 17'd1;
  assign q    = quot[15:8];
  assign sum  = {1'b0, s2_q} + {1'b0, q};

  always_comb begin
    if (over2_q) begin
      res_d = sum[8] ? 8'hFF : sum[7:0];
    end else begin
      res_d = s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_div) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/premultiplied_pixel_compositor.sv */
// Top level of the premultiplied pixel compositor: Src and Over, four-stage pipeline.
//
//   Channel   Direction  Fields, lowest bit first
//   s_axis    in         tdata: src_word[31:0], dst_word[63:32], visible[64], zero pad
//   m_axis    out        tdata: out_word[31:0], write_enable[32], status[34:33], zero pad
//   cfg       in         cfg_we_i, cfg_index_i (register index), cfg_data_i
//
// One pixel is accepted per clock while m_axis does not stall. Its result passes through
// stage 1, the lane multiply and divide stages and the output register before it is offered.
// The depth is set by the per-channel multiplier and the divide-by-255 stage that follows it.
// Reset is asynchronous and active low; it clears the valid bits and the configuration.
// A stall on m_axis freezes only the stages that are full, so bubbles are squeezed out
// and no pixel is lost or repeated.
module premultiplied_pixel_compositor
  import ppc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Pixel input: src_word [31:0], dst_word [63:32], visible [64], zeros [71:65].
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [71:0]         s_axis_tdata_i,
  // Result: out_word [31:0], write_enable [32], status [34:33], zeros [39:35].
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [39:0]         m_axis_tdata_o
);

  // Configuration registers. They are written only while the pipeline is empty, so the
  // stages may read them directly; the user is bound to this and the block does not enforce it.
  logic        blend_op_q;
  ppc_fmt_e    src_fmt_q, dst_fmt_q;
  logic        use_fill_q;
  logic [31:0] fill_color_q;
  logic        check_only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_op_q   <= 1'b0;
      src_fmt_q    <= FMT_ARGB;
      dst_fmt_q    <= FMT_ARGB;
      use_fill_q   <= 1'b0;
      fill_color_q <= 32'd0;
      check_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ppc_cfg_idx_e'(cfg_index_i))
        CFG_BLEND_OP:   blend_op_q   <= cfg_data_i[0];
        CFG_SRC_FORMAT: src_fmt_q    <= ppc_fmt_e'(cfg_data_i[1:0]);
        CFG_DST_FORMAT: dst_fmt_q    <= ppc_fmt_e'(cfg_data_i[1:0]);
        CFG_USE_FILL:   use_fill_q   <= cfg_data_i[0];
        CFG_FILL_COLOR: fill_color_q <= cfg_data_i;
        CFG_CHECK_ONLY: check_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain. A stage may load when it is empty or
  // when its content moves on in the same cycle.
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;

  assign en_o = !vo_q || m_axis_tready_i;
  assign en3  = !v3_q || en_o;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= s_axis_tvalid_i;
      if (en2)  v2_q <= v1_q;
      if (en3)  v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  // Stage 1: decode both pixels and settle the status. The destination is checked only for
  // Over, in fill mode only inside the clip region; in fill mode the source word is ignored.
  logic [31:0] src_word, dst_word;
  logic        visible;
  ppc_pix_t    s_pix, d_pix;
  ppc_status_e status_d;

  assign src_word = s_axis_tdata_i[31:0];
  assign dst_word = s_axis_tdata_i[63:32];
  assign visible  = s_axis_tdata_i[64];

  assign s_pix = use_fill_q ? ppc_decode(FMT_ARGB, fill_color_q)
                            : ppc_decode(src_fmt_q, src_word);
  assign d_pix = ppc_decode(dst_fmt_q, dst_word);

  always_comb begin
    priority if (!ppc_is_premult(s_pix)) begin
      status_d = use_fill_q ? ST_FILL : ST_SRC;
    end else if (blend_op_q && (!use_fill_q || visible) && !ppc_is_premult(d_pix)) begin
      status_d = ST_DST;
    end else begin
      status_d = ST_OK;
    end
  end

  ppc_pix_t    s1_s_q, s1_d_q;
  logic        s1_over_q, s1_wr_q;
  ppc_status_e s1_st_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_s_q    <= s_pix;
      s1_d_q    <= d_pix;
      s1_over_q <= blend_op_q;
      s1_wr_q   <= visible && !check_only_q;
      s1_st_q   <= status_d;
    end
  end

  // Stages 2 and 3 live in the four channel lanes; the side information rides along.
  ppc_lane_ctrl_t lane_ctrl;
  ppc_pix_t       blend;

  assign lane_ctrl.en_mul = en2;
  assign lane_ctrl.en_div = en3;

  ppc_over_lane u_lane_a (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .over_i (s1_over_q),
    .s_i    (s1_s_q.a),
    .d_i    (s1_d_q.a),
    .sa_i   (s1_s_q.a),
    .res_o  (blend.a)
  );

  ppc_over_lane u_lane_r (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .over_i (s1_over_q),
    .s_i    (s1_s_q.r),
    .d_i    (s1_d_q.r),
    .sa_i   (s1_s_q.a),
    .res_o  (blend.r)
  );

  ppc_over_lane u_lane_g (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .over_i (s1_over_q),
    .s_i    (s1_s_q.g),
    .d_i    (s1_d_q.g),
    .sa_i   (s1_s_q.a),
    .res_o  (blend.g)
  );

  ppc_over_lane u_lane_b (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .over_i (s1_over_q),
    .s_i    (s1_s_q.b),
    .d_i    (s1_d_q.b),
    .sa_i   (s1_s_q.a),
    .res_o  (blend.b)
  );

  logic        s2_wr_q, s3_wr_q;
  ppc_status_e s2_st_q, s3_st_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_wr_q <= s1_wr_q;
      s2_st_q <= s1_st_q;
    end
    if (en3) begin
      s3_wr_q <= s2_wr_q;
      s3_st_q <= s2_st_q;
    end
  end

  // Stage 4: encode into the destination format. An error clears the word and
  // the write; otherwise the write needs a visible pixel and check-only off.
  logic [31:0] out_word_d, out_word_q;
  logic        out_we_q;
  ppc_status_e out_st_q;

  assign out_word_d = (s3_st_q != ST_OK) ? 32'd0 : ppc_encode(dst_fmt_q, blend);

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_word_q <= out_word_d;
      out_we_q   <= (s3_st_q == ST_OK) && s3_wr_q;
      out_st_q   <= s3_st_q;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = {5'd0, out_st_q, out_we_q, out_word_q};

endmodule

/* rtl/ppc_checker.sv */
// Port-level assertions for the pixel compositor, bound to the top level.
module ppc_checker
  import ppc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  // Pixels accepted but not yet delivered; the pipeline holds at most four.
  logic [2:0] inflight_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 3'd0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  // A result needs an accepted pixel, and no more than four are in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || inflight_q != 3'd0) && inflight_q <= 3'd4)
    else $error("result without pixel or pipeline overfilled");

  // An error status clears both the word and the write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[34:33] != ST_OK |->
      m_axis_tdata_o[32:0] == 33'd0)
    else $error("error result carries a word or a write");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Nothing is offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result offered during reset");

endmodule

bind premultiplied_pixel_compositor ppc_checker u_ppc_checker (.*);
